### src/chl_pkg.sv
// Shared types, constants and helper functions for the C syntax highlight classifier.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package chl_pkg;

  // Window, keyword table and run queue sizes.
  localparam int LA_DEPTH        = 9;
  localparam int CNT_W           = $clog2(LA_DEPTH + 1);
  localparam int KW_COUNT        = 23;
  localparam int KW_MAXLEN       = 8;
  localparam int KW_IDX_W        = $clog2(KW_COUNT);
  localparam int KW_FIRST_SECOND = 15;
  localparam int RUNQ_DEPTH      = 4;
  localparam int RUNQ_CNT_W      = $clog2(RUNQ_DEPTH + 1);
  localparam int RUNQ_IDX_W      = $clog2(RUNQ_DEPTH);

  // Configuration register indexes.
  localparam logic [1:0] REG_SYNTAX = 2'd0;
  localparam logic [1:0] REG_NUMBER = 2'd1;
  localparam logic [1:0] REG_STRING = 2'd2;

  typedef enum logic [2:0] {
    CLS_NORMAL  = 3'd0,
    CLS_COMMENT = 3'd1,
    CLS_BLOCK   = 3'd2,
    CLS_KW1     = 3'd3,
    CLS_KW2     = 3'd4,
    CLS_STRING  = 3'd5,
    CLS_NUMBER  = 3'd6
  } hl_class_t;

  // One decision: a class that applies to len consecutive characters.
  typedef struct packed {
    hl_class_t        cls;
    logic [CNT_W-1:0] len;
    logic             last;
    logic             row_done;
    logic             comment_open;
  } run_t;

  // Separator test: white space, NUL and the operator punctuation.
  function automatic logic is_sep(input logic [7:0] c);
    return c inside {8'd0, 8'd32, [8'd9:8'd13], ",", ".", "(", ")", "+", "-", "/", "*",
                     "=", "~", "%", "<", ">", "[", "]", ";"};
  endfunction

  // Keyword text, right-justified: the first character sits in the highest used byte.
  function automatic logic [8*KW_MAXLEN-1:0] kw_word(input int j);
    logic [8*KW_MAXLEN-1:0] w;
    case (j)
      0:       w = 64'("switch");
      1:       w = 64'("if");
      2:       w = 64'("while");
      3:       w = 64'("for");
      4:       w = 64'("break");
      5:       w = 64'("continue");
      6:       w = 64'("return");
      7:       w = 64'("else");
      8:       w = 64'("struct");
      9:       w = 64'("union");
      10:      w = 64'("typedef");
      11:      w = 64'("static");
      12:      w = 64'("enum");
      13:      w = 64'("class");
      14:      w = 64'("case");
      15:      w = 64'("int");
      16:      w = 64'("long");
      17:      w = 64'("double");
      18:      w = 64'("float");
      19:      w = 64'("char");
      20:      w = 64'("unsigned");
      21:      w = 64'("signed");
      22:      w = 64'("void");
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic int kw_len(input int j);
    int n;
    case (j)
      1:                       n = 2;
      3, 15:                   n = 3;
      7, 12, 14, 16, 19, 22:   n = 4;
      2, 4, 9, 13, 18:         n = 5;
      0, 6, 8, 11, 17, 21:     n = 6;
      10:                      n = 7;
      5, 20:                   n = 8;
      default:                 n = KW_MAXLEN + 1;
    endcase
    return n;
  endfunction

  // Character m of keyword j, counted from its first character.
  function automatic logic [7:0] kw_char(input int j, input int m);
    logic [8*KW_MAXLEN-1:0] w;
    int                     n;
    w = kw_word(j);
    n = kw_len(j);
    if (m < n) return 8'(w >> (8 * (n - 1 - m)));
    return 8'd0;
  endfunction

endpackage

`default_nettype wire

### src/c_syntax_highlight_classifier.sv
// Top level of the C syntax highlight classifier: front end, run queue and
// output stage. Depends on chl_pkg, chl_front, chl_runq and chl_back.
//
// Usage: characters of a source row enter on the in_ stream, one byte per
// request in in_tdata, with in_tlast on the row's last character. For each
// character one highlight class leaves on the out_ stream, in order.
// out_tlast marks the last result caused by one input request; out_tuser[0]
// marks the row's final character and out_tuser[1] then tells whether a block
// comment is still open. A character is decided once eight more characters of
// its row have arrived (nine-character window) or the row ends. A row end
// flushes the window at one decision a cycle while the run queue is not full;
// in_tready stays low until the flush is done. Otherwise, while the queue has
// room, one character is taken each cycle, and each decision covers up to
// eight characters that the output stage then sends one per cycle while
// out_tready is high. A decision's run passes through the run queue and then
// the output register, which shows its first result. When the receiver
// stalls, the four-entry run queue fills and then in_tready drops; nothing is
// lost. Reset (rst_n low, synchronous) empties window and queue, enables all
// rules and closes any block comment. Configuration writes go through cfg_we.
`default_nettype none

module c_syntax_highlight_classifier (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] char_code
  input  wire         in_tlast,   // end_of_row
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [2:0] hl_class, [7:3] zero
  output logic        out_tlast,  // last_of_run
  output logic [1:0]  out_tuser,  // [0] row_done, [1] comment_open
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_addr,
  input  wire         cfg_wdata
);
  import chl_pkg::*;

  logic q_push, q_pop, q_full, q_empty;
  run_t q_in, q_out;

  chl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .push      (q_push),
    .push_data (q_in),
    .q_full    (q_full)
  );

  chl_runq u_runq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  chl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_data     (q_out),
    .q_empty    (q_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

### src/chl_front.sv
// Front end: accepts characters, holds the lookahead window and row state, and
// turns each classification decision into a run request. Uses chl_pkg.
`default_nettype none

module chl_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire  [7:0]           in_tdata,
  input  wire                  in_tlast,
  input  wire                  cfg_we,
  input  wire  [1:0]           cfg_addr,
  input  wire                  cfg_wdata,
  output logic                 push,
  output chl_pkg::run_t        push_data,
  input  wire                  q_full
);
  import chl_pkg::*;

  logic [7:0]       win_r [LA_DEPTH];
  logic [7:0]       win_nxt [LA_DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             flush_r, flush_nxt;
  logic             syn_r, num_r, str_r;
  logic             bc_r, bc_nxt;
  logic [7:0]       sq_r, sq_nxt;
  logic             esc_r, esc_nxt;
  logic             lc_r, lc_nxt;
  logic             ps_r, ps_nxt;
  hl_class_t        pc_r, pc_nxt;

  logic [7:0]       wa [LA_DEPTH];
  logic [CNT_W-1:0] na;
  logic             acc, ended, do_dec;
  logic [7:0]       c0, p1;
  logic [KW_COUNT-1:0] kw_hit;
  logic             kw_any;
  logic [KW_IDX_W-1:0] kw_j;
  hl_class_t        d_cls;
  logic [CNT_W-1:0] d_len, n_after;
  logic             digit;
  logic             row_end;

  // Input handshake: no new character while a row end is being flushed or the queue is full.
  assign in_tready = !flush_r && !q_full;
  assign acc       = in_tvalid && in_tready;
  assign ended     = flush_r || (acc && in_tlast);
  assign do_dec    = flush_r ? !q_full : (acc && (in_tlast || na == CNT_W'(LA_DEPTH)));

  // Window with the incoming character appended.
  always_comb begin
    for (int i = 0; i < LA_DEPTH; i++) begin
      wa[i] = (acc && cnt_r == CNT_W'(i)) ? in_tdata : win_r[i];
    end
    na = cnt_r + CNT_W'(acc);
  end

  assign c0    = wa[0];
  assign p1    = (na > CNT_W'(1)) ? wa[1] : 8'd0;
  assign digit = (c0 >= "0") && (c0 <= "9");

  // Keyword compare against the whole table in parallel.
  always_comb begin
    int  n;
    logic ok;
    logic after;
    for (int j = 0; j < KW_COUNT; j++) begin
      n  = kw_len(j);
      ok = (int'(na) >= n);
      for (int m = 0; m < KW_MAXLEN; m++) begin
        if (m < n && wa[m] != kw_char(j, m)) ok = 1'b0;
      end
      after     = (n < int'(na)) ? is_sep(wa[n % LA_DEPTH]) : ended;
      kw_hit[j] = ok && after;
    end
  end

  // First table entry that matches wins.
  always_comb begin
    kw_any = 1'b0;
    kw_j   = '0;
    for (int j = KW_COUNT - 1; j >= 0; j--) begin
      if (kw_hit[j]) begin
        kw_any = 1'b1;
        kw_j   = KW_IDX_W'(j);
      end
    end
  end

  // Classification of the window head.
  always_comb begin
    d_cls  = CLS_NORMAL;
    d_len  = CNT_W'(1);
    bc_nxt = bc_r;
    sq_nxt = sq_r;
    esc_nxt = esc_r;
    lc_nxt = lc_r;
    ps_nxt = ps_r;
    if (!syn_r) begin
      d_cls = CLS_NORMAL;
    end else if (lc_r) begin
      d_cls = CLS_COMMENT;
    end else if (sq_r == 8'd0 && !bc_r && c0 == "/" && p1 == "/") begin
      d_cls  = CLS_COMMENT;
      d_len  = CNT_W'(2);
      lc_nxt = 1'b1;
    end else if (sq_r == 8'd0 && bc_r) begin
      d_cls = CLS_BLOCK;
      if (c0 == "*" && p1 == "/") begin
        d_len  = CNT_W'(2);
        bc_nxt = 1'b0;
        ps_nxt = 1'b1;
      end
    end else if (sq_r == 8'd0 && c0 == "/" && p1 == "*") begin
      d_cls  = CLS_BLOCK;
      d_len  = CNT_W'(2);
      bc_nxt = 1'b1;
    end else if (str_r && sq_r != 8'd0) begin
      d_cls = CLS_STRING;
      if (esc_r) begin
        esc_nxt = 1'b0;
      end else if (c0 == "\\" && (na > CNT_W'(1) || !ended)) begin
        esc_nxt = 1'b1;
      end else begin
        if (c0 == sq_r) sq_nxt = 8'd0;
        ps_nxt = 1'b1;
      end
    end else if (str_r && (c0 == "\"" || c0 == "'")) begin
      d_cls  = CLS_STRING;
      sq_nxt = c0;
    end else if (num_r && ((digit && (ps_r || pc_r == CLS_NUMBER)) ||
                           (c0 == "." && pc_r == CLS_NUMBER))) begin
      d_cls  = CLS_NUMBER;
      ps_nxt = 1'b0;
    end else if (ps_r && kw_any) begin
      d_cls  = (int'(kw_j) >= KW_FIRST_SECOND) ? CLS_KW2 : CLS_KW1;
      d_len  = CNT_W'(kw_len(int'(kw_j)));
      ps_nxt = 1'b0;
    end else begin
      d_cls  = CLS_NORMAL;
      ps_nxt = is_sep(c0);
    end
    pc_nxt = d_cls;
  end

  assign n_after = na - d_len;
  assign row_end = do_dec && ended && n_after == '0;

  // Run request toward the queue.
  always_comb begin
    push                   = do_dec;
    push_data.cls          = d_cls;
    push_data.len          = d_len;
    push_data.last         = !ended || n_after == '0;
    push_data.row_done     = ended && n_after == '0;
    push_data.comment_open = ended && n_after == '0 && bc_nxt;
  end

  // Window shift after a decision, or plain append.
  always_comb begin
    logic [CNT_W:0] src;
    for (int i = 0; i < LA_DEPTH; i++) begin
      src = (CNT_W + 1)'(i) + {1'b0, d_len};
      if (do_dec && src < (CNT_W + 1)'(LA_DEPTH)) begin
        win_nxt[i] = wa[src[CNT_W-1:0]];
      end else begin
        win_nxt[i] = wa[i];
      end
    end
    if (row_end) begin
      cnt_nxt   = '0;
      flush_nxt = 1'b0;
    end else if (do_dec) begin
      cnt_nxt   = n_after;
      flush_nxt = ended;
    end else begin
      cnt_nxt   = na;
      flush_nxt = flush_r;
    end
  end

  // Window storage needs no reset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < LA_DEPTH; i++) win_r[i] <= win_nxt[i];
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      flush_r <= 1'b0;
      syn_r   <= 1'b1;
      num_r   <= 1'b1;
      str_r   <= 1'b1;
      bc_r    <= 1'b0;
      sq_r    <= 8'd0;
      esc_r   <= 1'b0;
      lc_r    <= 1'b0;
      ps_r    <= 1'b1;
      pc_r    <= CLS_NORMAL;
    end else begin
      cnt_r   <= cnt_nxt;
      flush_r <= flush_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_SYNTAX: syn_r <= cfg_wdata;
          REG_NUMBER: num_r <= cfg_wdata;
          REG_STRING: str_r <= cfg_wdata;
          default:    ;
        endcase
      end
      if (do_dec) begin
        bc_r <= bc_nxt;
        if (row_end) begin
          sq_r  <= 8'd0;
          esc_r <= 1'b0;
          lc_r  <= 1'b0;
          ps_r  <= 1'b1;
          pc_r  <= CLS_NORMAL;
        end else begin
          sq_r  <= sq_nxt;
          esc_r <= esc_nxt;
          lc_r  <= lc_nxt;
          ps_r  <= ps_nxt;
          pc_r  <= pc_nxt;
        end
      end
    end
  end

endmodule

`default_nettype wire

### src/chl_runq.sv
// Short queue of run requests between the front end and the output stage.
// Uses chl_pkg for the run type and depth.
`default_nettype none

module chl_runq (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  chl_pkg::run_t       push_data,
  input  wire                 pop,
  output chl_pkg::run_t       pop_data,
  output logic                full,
  output logic                empty
);
  import chl_pkg::*;

  run_t                  mem_r [RUNQ_DEPTH];
  logic [RUNQ_IDX_W-1:0] wp_r, rp_r;
  logic [RUNQ_CNT_W-1:0] cnt_r;
  logic                  do_push, do_pop;

  assign full     = cnt_r == RUNQ_CNT_W'(RUNQ_DEPTH);
  assign empty    = cnt_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rp_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + RUNQ_CNT_W'(do_push) - RUNQ_CNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

### src/chl_back.sv
// Output stage: expands each run request into one result per character and
// holds the result in an output register. Uses chl_pkg.
`default_nettype none

module chl_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  chl_pkg::run_t       q_data,
  input  wire                 q_empty,
  output logic                pop,
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast,
  output logic [1:0]          out_tuser
);
  import chl_pkg::*;

  run_t             run_r;
  logic             valid_r;
  logic [CNT_W-1:0] rem_r;
  logic             fire, final_one;

  assign fire      = valid_r && out_tready;
  assign final_one = rem_r == CNT_W'(1);
  assign pop       = !q_empty && (!valid_r || (fire && final_one));

  // Result fields come straight from the registers.
  assign out_tvalid = valid_r;
  assign out_tdata  = {5'd0, run_r.cls};
  assign out_tlast  = run_r.last && final_one;
  assign out_tuser  = {run_r.comment_open && final_one, run_r.row_done && final_one};

  always_ff @(posedge clk) begin
    if (pop) run_r <= q_data;
  end

  // Run counter and valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rem_r   <= '0;
    end else if (pop) begin
      valid_r <= 1'b1;
      rem_r   <= q_data.len;
    end else if (fire) begin
      rem_r   <= rem_r - 1'b1;
      valid_r <= !final_one;
    end
  end

`ifndef SYNTHESIS
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> rem_r != '0) else $error("run counter empty while result valid");
  a_row_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_tuser[0]) |-> out_tlast) else $error("row end not last of run");
  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> valid_r) else $error("loaded run not shown");
`endif

endmodule

`default_nettype wire
